// File: design/isl_pkg.sv
// isl_pkg: shared types, codes and constants of the indexed shift list.
// Used by the controller, the datapath and the top level; depends on nothing.
package isl_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int WORD_WIDTH_DEF = 32;

	localparam int REQ_W      = 3;
	localparam int POS_W      = 4;
	localparam int IO_WORD_W  = 32;
	localparam int CNT_OUT_W  = 5;
	localparam int STATUS_W   = 2;

	localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_INSERT,
		ACT_DELETE,
		ACT_POP,
		ACT_READ
	} act_t;

	typedef enum logic [2:0] {
		RD_BELOW,
		RD_ABOVE,
		RD_TARGET,
		RD_FRONT,
		RD_BACK
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_word;
		logic    idx_inc;
		logic    idx_dec;
		logic    count_inc;
		logic    count_dec;
		logic    cap_read;
		logic    cap_front;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic at_target;
		logic at_last;
	} stat_t;

endpackage

// File: design/isl_ram.sv
// isl_ram: generic single-write, single-read memory with a registered read.
// Self-contained; no package needed.
module isl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/isl_ctrl.sv
// isl_ctrl: sequencing state machine of the indexed shift list.
// Depends on isl_pkg for the command and status structs.
module isl_ctrl import isl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	typedef enum logic [9:0] {
		S_IDLE      = 10'b00_0000_0001,
		S_DISPATCH  = 10'b00_0000_0010,
		S_INS_STEP  = 10'b00_0000_0100,
		S_INS_MOVE  = 10'b00_0000_1000,
		S_DEL_STEP  = 10'b00_0001_0000,
		S_DEL_MOVE  = 10'b00_0010_0000,
		S_RD_CAP    = 10'b00_0100_0000,
		S_FRONT_RD  = 10'b00_1000_0000,
		S_FRONT_CAP = 10'b01_0000_0000,
		S_BACK_CAP  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.act)
					ACT_INSERT: begin
						state_d = S_INS_STEP;
					end
					ACT_DELETE: begin
						state_d = S_DEL_STEP;
					end
					ACT_POP: begin
						cmd.count_dec = 1'b1;
						state_d       = S_FRONT_RD;
					end
					ACT_READ: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_TARGET;
						state_d    = S_RD_CAP;
					end
					default: begin
						state_d = S_FRONT_RD;
					end
				endcase
			end
			S_INS_STEP: begin
				if (stat.at_target) begin
					cmd.wr_en     = 1'b1;
					cmd.wr_word   = 1'b1;
					cmd.count_inc = 1'b1;
					state_d       = S_FRONT_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_BELOW;
					state_d    = S_INS_MOVE;
				end
			end
			S_INS_MOVE: begin
				cmd.wr_en   = 1'b1;
				cmd.idx_dec = 1'b1;
				state_d     = S_INS_STEP;
			end
			S_DEL_STEP: begin
				if (stat.at_last) begin
					cmd.count_dec = 1'b1;
					state_d       = S_FRONT_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_ABOVE;
					state_d    = S_DEL_MOVE;
				end
			end
			S_DEL_MOVE: begin
				cmd.wr_en   = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_DEL_STEP;
			end
			S_RD_CAP: begin
				cmd.cap_read = 1'b1;
				state_d      = S_FRONT_RD;
			end
			S_FRONT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_FRONT;
				state_d    = S_FRONT_CAP;
			end
			S_FRONT_CAP: begin
				cmd.cap_front = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RD_BACK;
				state_d       = S_BACK_CAP;
			end
			S_BACK_CAP: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: design/isl_datapath.sv
// isl_datapath: request decode, entry memory, index and count registers, result registers.
// Depends on isl_pkg and instantiates isl_ram.
module isl_datapath import isl_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [POS_W-1:0]     position,
	input  logic [IO_WORD_W-1:0] word_in,
	output logic                 done,
	output logic [IO_WORD_W-1:0] read_word,
	output logic [IO_WORD_W-1:0] front_word,
	output logic [IO_WORD_W-1:0] back_word,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic [STATUS_W-1:0]  status
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]         count_q, idx_q, target_q, idx_m1, idx_p1, count_m1;
	act_t                  act_q, act_d;
	logic [STATUS_W-1:0]   req_status_q, status_d;
	logic                  ins_tail, pos_ge, is_empty, is_full;
	logic [WORD_WIDTH-1:0] word_q, rd_q, front_q, rdata, wdata;
	logic [AW-1:0]         raddr;

	logic                  done_q;
	logic [IO_WORD_W-1:0]  read_word_q, front_word_q, back_word_q;
	logic [CNT_OUT_W-1:0]  entry_count_q;
	logic [STATUS_W-1:0]   out_status_q;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(CAPACITY));
	assign pos_ge   = (CMPW'(position) >= CMPW'(count_q));

	// Request decode against the count held before the request.
	always_comb begin
		act_d    = ACT_NONE;
		status_d = ST_OK;
		ins_tail = 1'b0;
		unique case (req_type)
			REQ_APPEND: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					act_d    = ACT_INSERT;
					ins_tail = 1'b1;
				end
			end
			REQ_POP: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					act_d = ACT_POP;
				end
			end
			REQ_INSERT: begin
				if (is_empty && (position == '0)) begin
					act_d    = ACT_INSERT;
					ins_tail = 1'b1;
				end else if (pos_ge) begin
					status_d = ST_BAD_INDEX;
				end else if (is_full) begin
					status_d = ST_FULL;
				end else begin
					act_d = ACT_INSERT;
				end
			end
			REQ_DELETE: begin
				if (pos_ge) begin
					status_d = ST_BAD_INDEX;
				end else begin
					act_d = ACT_DELETE;
				end
			end
			REQ_READ: begin
				if (pos_ge) begin
					status_d = ST_BAD_INDEX;
				end else begin
					act_d = ACT_READ;
				end
			end
			default: begin
				act_d = ACT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q        <= ACT_NONE;
			req_status_q <= ST_OK;
			count_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				act_q        <= act_d;
				req_status_q <= status_d;
			end
			if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.count_dec) begin
				count_q <= count_m1;
			end
		end
	end

	assign idx_m1   = idx_q - 1'b1;
	assign idx_p1   = idx_q + 1'b1;
	assign count_m1 = count_q - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q   <= WORD_WIDTH'(word_in);
			target_q <= ins_tail ? count_q : CW'(position);
			idx_q    <= (act_d == ACT_INSERT) ? count_q : CW'(position);
		end else if (cmd.idx_dec) begin
			idx_q <= idx_m1;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_p1;
		end
		if (cmd.load) begin
			rd_q <= '0;
		end else if (cmd.cap_read) begin
			rd_q <= rdata;
		end
		if (cmd.cap_front) begin
			front_q <= rdata;
		end
		if (cmd.finish) begin
			read_word_q   <= IO_WORD_W'(rd_q);
			front_word_q  <= is_empty ? '0 : IO_WORD_W'(front_q);
			back_word_q   <= is_empty ? '0 : IO_WORD_W'(rdata);
			entry_count_q <= CNT_OUT_W'(count_q);
			out_status_q  <= req_status_q;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_BELOW:  raddr = idx_m1[AW-1:0];
			RD_ABOVE:  raddr = idx_p1[AW-1:0];
			RD_TARGET: raddr = target_q[AW-1:0];
			RD_BACK:   raddr = count_m1[AW-1:0];
			default:   raddr = '0;
		endcase
	end

	assign wdata = cmd.wr_word ? word_q : rdata;

	isl_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (idx_q[AW-1:0]),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign stat.act       = act_q;
	assign stat.at_target = (idx_q == target_q);
	assign stat.at_last   = (idx_p1 == count_q);

	assign done        = done_q;
	assign read_word   = read_word_q;
	assign front_word  = front_word_q;
	assign back_word   = back_word_q;
	assign entry_count = entry_count_q;
	assign status      = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (idx_q < CW'(CAPACITY)))
		else $error("entry write beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_inc |-> (!cmd.count_dec && !is_full))
		else $error("count grows past capacity or moves both ways");

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.finish))
		else $error("result strobe without a finished request");

endmodule

// File: design/indexed_shift_list.sv
// indexed_shift_list: top level of a fixed-capacity ordered list of words.
// Depends on isl_pkg; instantiates isl_ctrl and isl_datapath (which holds isl_ram).
//
// A request is transferred at a rising edge where start is high and busy is low. It is one of
// append, remove last, insert at position, delete at position or read at position. Exactly
// one result follows: done is high for a single cycle, and read_word, front_word, back_word,
// entry_count and status are valid in that cycle and must be taken then, as the block cannot
// be held off. The result cycle is also a cycle in which busy is low, so the next request may
// be transferred at the very edge that takes the result. The entries live in a single-port-
// write, single-port-read memory with a registered read; every request ends by reading the
// first and last entries back from it, and an insert or delete moves the entries one at a time
// through that memory, each by a read state and then a write state. A failed request leaves
// the list unchanged and reports status 1 for a bad index, 2 for an empty list or 3 for a
// full list. No clearing pass is needed after reset.
module indexed_shift_list import isl_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [POS_W-1:0]     position,
	input  logic [IO_WORD_W-1:0] word_in,
	output logic                 done,
	output logic [IO_WORD_W-1:0] read_word,
	output logic [IO_WORD_W-1:0] front_word,
	output logic [IO_WORD_W-1:0] back_word,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic [STATUS_W-1:0]  status
);

	// The controller and datapath talk only through these two structs.
	cmd_t  cmd;
	stat_t stat;

	// The controller sequences each request: decode, the shifting loop for an insert or
	// delete, the indexed read, and the closing reads of the first and last entries.
	isl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the entry memory, the count, the moving index and the
	// result registers that drive the ports for the single done cycle.
	isl_datapath #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req_type),
		.position    (position),
		.word_in     (word_in),
		.done        (done),
		.read_word   (read_word),
		.front_word  (front_word),
		.back_word   (back_word),
		.entry_count (entry_count),
		.status      (status)
	);

endmodule
